/* rtl/tpcm_pkg.sv */
// Shared types, constants and codes for the touch point calibrate and map unit.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package tpcm_pkg;

    // Panel geometry and raw coordinate width.
    localparam int PANEL_WIDTH   = 240;
    localparam int PANEL_HEIGHT  = 320;
    localparam int TARGET_MARGIN = 20;
    localparam int RAW_BITS      = 12;

    // Target spans between the calibration targets on each axis.
    localparam int SPAN_X = PANEL_WIDTH - 2 * TARGET_MARGIN - 1;
    localparam int SPAN_Y = PANEL_HEIGHT - 2 * TARGET_MARGIN - 1;

    // Result field widths.
    localparam int SX_W = 8;
    localparam int SY_W = 9;

    // Internal widths.
    // C_W holds a sum of two raw values, DIFF_W the signed term 2*raw - c,
    // SPAN2_W twice the largest span, N_W the signed numerator and M_W its
    // magnitude, which is also the number of divider steps.
    localparam int C_W     = RAW_BITS + 1;
    localparam int DIFF_W  = RAW_BITS + 2;
    localparam int FIT_W   = C_W + 1;
    localparam int D_W     = C_W + 1;
    localparam int SPAN2_W = 12;
    localparam int LIM_W   = 11;
    localparam int N_W     = DIFF_W + SPAN2_W + 1;
    localparam int M_W     = N_W - 1;
    localparam int CNT_W   = $clog2(M_W + 1);

    // Action codes.
    localparam logic ACT_CONVERT = 1'b0;
    localparam logic ACT_CAPTURE = 1'b1;

    // Calibration corner codes.
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_CONV    = 2'd0,
        ST_TAP     = 2'd1,
        ST_FIT_OK  = 2'd2,
        ST_FIT_REJ = 2'd3
    } t_status;

    // Mapping coefficients of one axis: slope sum and centre sum.
    typedef struct packed {
        logic [C_W-1:0] slope;
        logic [C_W-1:0] centre;
    } t_axis_coef;

endpackage

/* rtl/tpcm_fit.sv */
// Calibration tap stores, four-point fit and mapping coefficient registers.
// Depends on tpcm_pkg.
`timescale 1ns / 1ps

module tpcm_fit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [1:0]                      i_idx,
    input  logic [tpcm_pkg::RAW_BITS-1:0]   i_raw_x,
    input  logic [tpcm_pkg::RAW_BITS-1:0]   i_raw_y,
    input  logic                            i_fit,
    output logic                            o_fit_ok,
    output tpcm_pkg::t_axis_coef            o_coef_x,
    output tpcm_pkg::t_axis_coef            o_coef_y
);
    import tpcm_pkg::*;

    localparam logic signed [FIT_W-1:0] SPAN_X_S = FIT_W'(SPAN_X);
    localparam logic signed [FIT_W-1:0] SPAN_Y_S = FIT_W'(SPAN_Y);

    logic [RAW_BITS-1:0]     r_tap_x [4];
    logic [RAW_BITS-1:0]     r_tap_y [4];
    logic signed [FIT_W-1:0] w_dx;
    logic signed [FIT_W-1:0] w_dy;
    logic [C_W-1:0]          w_cx;
    logic [C_W-1:0]          w_cy;
    t_axis_coef              r_coef_x;
    t_axis_coef              r_coef_y;

    // Tap stores: one corner is written per capture transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_tap_x[i] <= '0;
                r_tap_y[i] <= '0;
            end
        end else if (i_wr) begin
            r_tap_x[i_idx] <= i_raw_x;
            r_tap_y[i_idx] <= i_raw_y;
        end
    end

    // Slope sums from the top and bottom rows (x) and the left and right
    // columns (y); centre sums from the left column (x) and the top row (y).
    always_comb begin
        w_dx = $signed(FIT_W'(r_tap_x[CORNER_TR])) - $signed(FIT_W'(r_tap_x[CORNER_TL]))
             + $signed(FIT_W'(r_tap_x[CORNER_BR])) - $signed(FIT_W'(r_tap_x[CORNER_BL]));
        w_dy = $signed(FIT_W'(r_tap_y[CORNER_BL])) - $signed(FIT_W'(r_tap_y[CORNER_TL]))
             + $signed(FIT_W'(r_tap_y[CORNER_BR])) - $signed(FIT_W'(r_tap_y[CORNER_TR]));
        w_cx = C_W'(r_tap_x[CORNER_TL]) + C_W'(r_tap_x[CORNER_BL]);
        w_cy = C_W'(r_tap_y[CORNER_TL]) + C_W'(r_tap_y[CORNER_TR]);
    end

    // A fit is usable only when both slope sums exceed the target spans.
    assign o_fit_ok = (w_dx > SPAN_X_S) && (w_dy > SPAN_Y_S);

    // Coefficients reset to the identity mapping and change only on a good fit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x.slope  <= C_W'(2 * SPAN_X);
            r_coef_x.centre <= C_W'(2 * TARGET_MARGIN);
            r_coef_y.slope  <= C_W'(2 * SPAN_Y);
            r_coef_y.centre <= C_W'(2 * TARGET_MARGIN);
        end else if (i_fit && o_fit_ok) begin
            r_coef_x.slope  <= w_dx[C_W-1:0];
            r_coef_x.centre <= w_cx;
            r_coef_y.slope  <= w_dy[C_W-1:0];
            r_coef_y.centre <= w_cy;
        end
    end

    assign o_coef_x = r_coef_x;
    assign o_coef_y = r_coef_y;

endmodule

/* rtl/tpcm_lane.sv */
// One axis of the coordinate mapper: numerator product, bit-serial restoring
// divider and margin offset with clamping. Depends on tpcm_pkg.
`timescale 1ns / 1ps

module tpcm_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [tpcm_pkg::RAW_BITS-1:0]   i_raw,
    input  tpcm_pkg::t_axis_coef            i_coef,
    input  logic [tpcm_pkg::SPAN2_W-1:0]    i_span2,
    input  logic [tpcm_pkg::LIM_W-1:0]      i_limit_m1,
    output logic                            o_done,
    output logic [tpcm_pkg::LIM_W-1:0]      o_screen
);
    import tpcm_pkg::*;

    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_MUL  = 5'b00010,
        L_FOLD = 5'b00100,
        L_DIV  = 5'b01000,
        L_FIN  = 5'b10000
    } t_lane_state;

    t_lane_state              r_state;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [N_W-1:0]    r_prod;
    logic signed [N_W-1:0]    w_num;
    logic                     r_neg;
    logic [M_W-1:0]           r_m;
    logic [D_W-1:0]           r_rem;
    logic [D_W:0]             w_rem_sh;
    logic [D_W-1:0]           w_den;
    logic                     w_qbit;
    logic [CNT_W-1:0]         r_cnt;
    logic [LIM_W-1:0]         w_scr;
    logic [LIM_W-1:0]         r_scr;
    logic                     r_done;

    // Numerator n = 2*(2*raw - c)*span + d; its product is already times two
    // through the doubled span.
    assign w_num = r_prod + $signed(N_W'(i_coef.slope));

    // Divisor 2*d and one restoring step: shift in the next magnitude bit.
    assign w_den    = {i_coef.slope, 1'b0};
    assign w_rem_sh = {r_rem, r_m[M_W-1]};
    assign w_qbit   = (w_rem_sh >= (D_W+1)'(w_den));

    // Floor of a negative quotient is -(m/D)-1 with m = -n-1; add the margin
    // and clamp to the panel.
    always_comb begin
        if (r_neg) begin
            if (r_m >= M_W'(TARGET_MARGIN)) begin
                w_scr = '0;
            end else begin
                w_scr = LIM_W'(TARGET_MARGIN - 1) - r_m[LIM_W-1:0];
            end
        end else begin
            if (r_m >= (M_W'(i_limit_m1) - M_W'(TARGET_MARGIN))) begin
                w_scr = i_limit_m1;
            end else begin
                w_scr = r_m[LIM_W-1:0] + LIM_W'(TARGET_MARGIN);
            end
        end
    end

    // Lane sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_state <= L_FOLD;
                end
                L_FOLD: begin
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= L_FIN;
                    end
                end
                L_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_diff <= $signed({1'b0, i_raw, 1'b0}) - $signed({1'b0, i_coef.centre});
            end
            L_MUL: begin
                r_prod <= r_diff * $signed({1'b0, i_span2});
            end
            L_FOLD: begin
                r_neg <= w_num[N_W-1];
                r_m   <= w_num[N_W-1] ? ~w_num[M_W-1:0] : w_num[M_W-1:0];
                r_rem <= '0;
                r_cnt <= CNT_W'(M_W - 1);
            end
            L_DIV: begin
                r_rem <= w_qbit ? D_W'(w_rem_sh - (D_W+1)'(w_den)) : w_rem_sh[D_W-1:0];
                r_m   <= {r_m[M_W-2:0], w_qbit};
                r_cnt <= r_cnt - 1'b1;
            end
            L_FIN: begin
                r_scr <= w_scr;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_screen = r_scr;

endmodule

/* rtl/touch_point_calibrate_and_map_unit.sv */
// Touch point calibrate and map unit: a conversion passes through the 26-step bit-serial
// divider in each axis lane; the capture of the last corner also passes a fit state. One
// transaction is worked at a time; a result waiting in the output register does not stop
// the next accept. Synchronous active-low reset restores the identity mapping and clears
// the tap stores. Depends on tpcm_pkg.
`timescale 1ns / 1ps

module touch_point_calibrate_and_map_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [1:0]                      i_point_index,
    input  logic [tpcm_pkg::RAW_BITS-1:0]   i_raw_x,
    input  logic [tpcm_pkg::RAW_BITS-1:0]   i_raw_y,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tpcm_pkg::SX_W-1:0]       o_screen_x,
    output logic [tpcm_pkg::SY_W-1:0]       o_screen_y,
    output logic [1:0]                      o_status
);
    import tpcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIT  = 4'b0010,
        S_CONV = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [SX_W-1:0]   r_res_sx, n_res_sx;
    logic [SY_W-1:0]   r_res_sy, n_res_sy;
    t_status           r_res_status, n_res_status;
    logic              r_out_valid;
    logic [SX_W-1:0]   r_out_sx;
    logic [SY_W-1:0]   r_out_sy;
    t_status           r_out_status;
    logic              w_in_acc;
    logic              w_load_out;
    logic              w_fit_ok;
    t_axis_coef        w_coef_x;
    t_axis_coef        w_coef_y;
    logic              w_done_x;
    logic              w_done_y;
    logic [LIM_W-1:0]  w_scr_x;
    logic [LIM_W-1:0]  w_scr_y;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Tap stores and coefficients.
    tpcm_fit u_fit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_in_acc && (i_action == ACT_CAPTURE)),
        .i_idx    (i_point_index),
        .i_raw_x  (i_raw_x),
        .i_raw_y  (i_raw_y),
        .i_fit    (r_state == S_FIT),
        .o_fit_ok (w_fit_ok),
        .o_coef_x (w_coef_x),
        .o_coef_y (w_coef_y)
    );

    // One mapping lane per axis; both run in lockstep.
    tpcm_lane u_lane_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc && (i_action == ACT_CONVERT)),
        .i_raw      (i_raw_x),
        .i_coef     (w_coef_x),
        .i_span2    (SPAN2_W'(2 * SPAN_X)),
        .i_limit_m1 (LIM_W'(PANEL_WIDTH - 1)),
        .o_done     (w_done_x),
        .o_screen   (w_scr_x)
    );

    tpcm_lane u_lane_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc && (i_action == ACT_CONVERT)),
        .i_raw      (i_raw_y),
        .i_coef     (w_coef_y),
        .i_span2    (SPAN2_W'(2 * SPAN_Y)),
        .i_limit_m1 (LIM_W'(PANEL_HEIGHT - 1)),
        .o_done     (w_done_y),
        .o_screen   (w_scr_y)
    );

    // Transaction sequencer.
    always_comb begin
        n_state      = r_state;
        n_res_sx     = r_res_sx;
        n_res_sy     = r_res_sy;
        n_res_status = r_res_status;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_action == ACT_CAPTURE) begin
                        if (i_point_index == CORNER_BR) begin
                            n_state = S_FIT;
                        end else begin
                            n_res_sx     = '0;
                            n_res_sy     = '0;
                            n_res_status = ST_TAP;
                            n_state      = S_OUT;
                        end
                    end else begin
                        n_state = S_CONV;
                    end
                end
            end
            S_FIT: begin
                n_res_sx     = '0;
                n_res_sy     = '0;
                n_res_status = w_fit_ok ? ST_FIT_OK : ST_FIT_REJ;
                n_state      = S_OUT;
            end
            S_CONV: begin
                if (w_done_x) begin
                    n_res_sx     = w_scr_x[SX_W-1:0];
                    n_res_sy     = w_scr_y[SY_W-1:0];
                    n_res_status = ST_CONV;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result and output payload registers.
    always_ff @(posedge i_clk) begin
        r_res_sx     <= n_res_sx;
        r_res_sy     <= n_res_sy;
        r_res_status <= n_res_status;
        if (w_load_out) begin
            r_out_sx     <= r_res_sx;
            r_out_sy     <= r_res_sy;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_screen_x  = r_out_sx;
    assign o_screen_y  = r_out_sy;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    // Both lanes finish in the same cycle.
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_x == w_done_y)
        else $error("axis lanes finished in different cycles");

    // A held result leaves only when the consumer takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("output transaction dropped without ready");

    // Converted points lie on the panel.
    a_conv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_CONV)) |->
        ((o_screen_x <= SX_W'(PANEL_WIDTH - 1)) && (o_screen_y <= SY_W'(PANEL_HEIGHT - 1))))
        else $error("converted point outside the panel");

    // Capture results carry zero coordinates.
    a_capture_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_CONV)) |-> ((o_screen_x == '0) && (o_screen_y == '0)))
        else $error("capture result with nonzero coordinates");
`endif

endmodule

/* bench/tb.sv */
// Self-checking bench for touch_point_calibrate_and_map_unit: corner taps, fits and conversions
// are checked against an in-bench calibration predictor, under several sender and receiver
// idle mixes. Depends on tpcm_pkg and the RTL in rtl/.
`timescale 1ns / 1ps

module tb;
    import tpcm_pkg::*;

    // One expected result transaction.
    typedef struct packed {
        logic [SX_W-1:0] screen_x;
        logic [SY_W-1:0] screen_y;
        t_status         status;
    } t_screen_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic                i_action      = ACT_CONVERT;
    logic [1:0]          i_point_index = CORNER_TL;
    logic [RAW_BITS-1:0] i_raw_x       = '0;
    logic [RAW_BITS-1:0] i_raw_y       = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [SX_W-1:0]     o_screen_x;
    logic [SY_W-1:0]     o_screen_y;
    logic [1:0]          o_status;

    // Predicted calibration state: stored corner taps and per-axis sums.
    logic [RAW_BITS-1:0] corner_tap_x [4];
    logic [RAW_BITS-1:0] corner_tap_y [4];
    longint              x_slope;
    longint              x_centre;
    longint              y_slope;
    longint              y_centre;

    t_screen_result      pending_screen_results [$];
    int                  mismatch_count = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    touch_point_calibrate_and_map_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_point_index (i_point_index),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_status      (o_status)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Map one raw coordinate through the linear fit, rounding to nearest and clamping.
    function automatic longint screen_coord(input longint raw, input longint slope,
                                            input longint centre, input longint span,
                                            input longint limit);
        longint num;
        longint quo;
        num = 2 * (2 * raw - centre) * span + slope;
        if (num >= 0) begin
            quo = num / (2 * slope);
        end else begin
            quo = -((-num + 2 * slope - 1) / (2 * slope));
        end
        quo = quo + TARGET_MARGIN;
        if (quo < 0) begin
            quo = 0;
        end
        if (quo > limit - 1) begin
            quo = limit - 1;
        end
        return quo;
    endfunction

    // Apply one accepted transaction to the predicted state and return its result.
    function automatic t_screen_result calibrate_and_map(input logic action,
                                                         input logic [1:0] corner,
                                                         input logic [RAW_BITS-1:0] rx,
                                                         input logic [RAW_BITS-1:0] ry);
        t_screen_result res;
        longint         dx;
        longint         dy;
        res = '0;
        if (action == ACT_CONVERT) begin
            res.screen_x = SX_W'(screen_coord(rx, x_slope, x_centre, SPAN_X, PANEL_WIDTH));
            res.screen_y = SY_W'(screen_coord(ry, y_slope, y_centre, SPAN_Y, PANEL_HEIGHT));
            res.status   = ST_CONV;
        end else begin
            corner_tap_x[corner] = rx;
            corner_tap_y[corner] = ry;
            if (corner != CORNER_BR) begin
                res.status = ST_TAP;
            end else begin
                // Slope from top and bottom rows for x, left and right columns for y.
                dx = (longint'(corner_tap_x[CORNER_TR]) - longint'(corner_tap_x[CORNER_TL]))
                   + (longint'(corner_tap_x[CORNER_BR]) - longint'(corner_tap_x[CORNER_BL]));
                dy = (longint'(corner_tap_y[CORNER_BL]) - longint'(corner_tap_y[CORNER_TL]))
                   + (longint'(corner_tap_y[CORNER_BR]) - longint'(corner_tap_y[CORNER_TR]));
                if (dx > SPAN_X && dy > SPAN_Y && dx > 0 && dy > 0) begin
                    x_slope    = dx;
                    y_slope    = dy;
                    x_centre   = longint'(corner_tap_x[CORNER_TL])
                               + longint'(corner_tap_x[CORNER_BL]);
                    y_centre   = longint'(corner_tap_y[CORNER_TL])
                               + longint'(corner_tap_y[CORNER_TR]);
                    res.status = ST_FIT_OK;
                end else begin
                    res.status = ST_FIT_REJ;
                end
            end
        end
        return res;
    endfunction

    // Raw value jittered around a nominal tap position, kept within the raw range.
    function automatic logic [RAW_BITS-1:0] near_raw(input int nominal);
        int v;
        v = nominal + int'($urandom_range(40)) - 20;
        if (v < 0) begin
            v = 0;
        end
        if (v > (1 << RAW_BITS) - 1) begin
            v = (1 << RAW_BITS) - 1;
        end
        return RAW_BITS'(v);
    endfunction

    // Print one line for a mismatch, quietly after the first few, and count it.
    task automatic report_mismatch(input string what);
        if (mismatch_count < 20) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Send one transaction; returns at the edge where it is accepted, valid still high.
    task automatic send_item(input logic action, input logic [1:0] corner,
                             input logic [RAW_BITS-1:0] rx, input logic [RAW_BITS-1:0] ry);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_action      <= action;
        i_point_index <= corner;
        i_raw_x       <= rx;
        i_raw_y       <= ry;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_screen_results.push_back(calibrate_and_map(action, corner, rx, ry));
    endtask

    // Receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_screen_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_screen_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d status=%0d",
                                          o_screen_x, o_screen_y, o_status));
            end else begin
                want = pending_screen_results.pop_front();
                if (o_screen_x !== want.screen_x) begin
                    report_mismatch($sformatf("screen_x got %0d want %0d",
                                              o_screen_x, want.screen_x));
                end
                if (o_screen_y !== want.screen_y) begin
                    report_mismatch($sformatf("screen_y got %0d want %0d",
                                              o_screen_y, want.screen_y));
                end
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                end
            end
        end
    end

    // Reset mapping is the identity; probe the raw extremes and the panel edges.
    task automatic test_identity_map();
        send_item(ACT_CONVERT, CORNER_TL, '0, '0);
        send_item(ACT_CONVERT, CORNER_BR, '1, '1);
        send_item(ACT_CONVERT, CORNER_TR, 12'd239, 12'd319);
    endtask

    // A clean four-corner calibration, then conversions at the centre and beyond the corners.
    task automatic test_corner_fit();
        send_item(ACT_CAPTURE, CORNER_TL, 12'd300, 12'd400);
        send_item(ACT_CAPTURE, CORNER_TR, 12'd3800, 12'd420);
        send_item(ACT_CAPTURE, CORNER_BL, 12'd310, 12'd3700);
        send_item(ACT_CAPTURE, CORNER_BR, 12'd3790, 12'd3680);
        send_item(ACT_CONVERT, CORNER_BL, 12'd2050, 12'd2050);
        send_item(ACT_CONVERT, CORNER_TL, '0, '0);
        send_item(ACT_CONVERT, CORNER_BR, '1, '1);
    endtask

    // Collapsed and just-too-narrow fits keep the old sums; the boundary fit is accepted.
    task automatic test_rejected_fit();
        send_item(ACT_CAPTURE, CORNER_TR, 12'd310, 12'd420);
        send_item(ACT_CAPTURE, CORNER_BR, 12'd320, 12'd3680);
        send_item(ACT_CONVERT, CORNER_TL, 12'd1000, 12'd3000);
        send_item(ACT_CAPTURE, CORNER_TL, 12'd1000, 12'd1000);
        send_item(ACT_CAPTURE, CORNER_TR, 12'd1100, 12'd1000);
        send_item(ACT_CAPTURE, CORNER_BL, 12'd1000, 12'd1140);
        // Slope sum of x equal to the span, so the fit is rejected.
        send_item(ACT_CAPTURE, CORNER_BR, 12'd1099, 12'd1140);
        // Smallest accepted slope sums: narrow mapping that saturates quickly.
        send_item(ACT_CAPTURE, CORNER_BR, 12'd1100, 12'd1140);
        // Slope sum of y equal to the span, so the fit is rejected.
        send_item(ACT_CAPTURE, CORNER_BR, 12'd1100, 12'd1139);
        send_item(ACT_CONVERT, CORNER_TR, 12'd1050, 12'd4000);
    endtask

    // Out-of-order taps: the fit uses whatever stale taps the stores hold.
    task automatic test_stale_taps();
        send_item(ACT_CAPTURE, CORNER_BR, 12'd4095, 12'd4095);
        send_item(ACT_CAPTURE, CORNER_TL, 12'd0, 12'd0);
        send_item(ACT_CAPTURE, CORNER_BR, 12'd2048, 12'd2048);
        send_item(ACT_CONVERT, CORNER_BL, 12'd1500, 12'd2600);
    endtask

    // Mostly well-formed calibrations followed by conversions, plus stray taps and points.
    task automatic test_random_traffic(input int item_count);
        int sent;
        int kind;
        int x_lo;
        int x_hi;
        int y_lo;
        int y_hi;
        int swap;
        int conv_count;
        sent = 0;
        while (sent < item_count) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                x_lo = $urandom_range(1800);
                x_hi = $urandom_range(x_lo + 60, 4095);
                y_lo = $urandom_range(1800);
                y_hi = $urandom_range(y_lo + 80, 4095);
                // Occasionally a mirrored panel, which the fit rejects.
                if ($urandom_range(9) == 0) begin
                    swap = x_lo;
                    x_lo = x_hi;
                    x_hi = swap;
                end
                if ($urandom_range(9) == 0) begin
                    swap = y_lo;
                    y_lo = y_hi;
                    y_hi = swap;
                end
                send_item(ACT_CAPTURE, CORNER_TL, near_raw(x_lo), near_raw(y_lo));
                send_item(ACT_CAPTURE, CORNER_TR, near_raw(x_hi), near_raw(y_lo));
                send_item(ACT_CAPTURE, CORNER_BL, near_raw(x_lo), near_raw(y_hi));
                send_item(ACT_CAPTURE, CORNER_BR, near_raw(x_hi), near_raw(y_hi));
                conv_count = $urandom_range(1, 6);
                repeat (conv_count) begin
                    if ($urandom_range(1) == 0) begin
                        send_item(ACT_CONVERT, 2'($urandom),
                                  RAW_BITS'($urandom_range(x_lo, x_hi)),
                                  RAW_BITS'($urandom_range(y_lo, y_hi)));
                    end else begin
                        send_item(ACT_CONVERT, 2'($urandom), RAW_BITS'($urandom),
                                  RAW_BITS'($urandom));
                    end
                end
                sent += 4 + conv_count;
            end else if (kind < 8) begin
                send_item(ACT_CAPTURE, 2'($urandom), RAW_BITS'($urandom), RAW_BITS'($urandom));
                sent++;
            end else begin
                send_item(ACT_CONVERT, 2'($urandom), RAW_BITS'($urandom), RAW_BITS'($urandom));
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed checks, then random traffic over the idle mixes.
    initial begin
        for (int k = 0; k < 4; k++) begin
            corner_tap_x[k] = '0;
            corner_tap_y[k] = '0;
        end
        x_slope  = 2 * SPAN_X;
        y_slope  = 2 * SPAN_Y;
        x_centre = 2 * TARGET_MARGIN;
        y_centre = 2 * TARGET_MARGIN;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_map();
        test_corner_fit();
        test_rejected_fit();
        test_stale_taps();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(300);
        send_idle_pct  = 55;
        recv_stall_pct = 0;
        test_random_traffic(300);
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        test_random_traffic(300);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        test_random_traffic(300);
        i_in_valid <= 1'b0;

        // Drain the remaining results, then watch for stray ones.
        while (pending_screen_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tpcm_pkg.sv
rtl/tpcm_fit.sv
rtl/tpcm_lane.sv
rtl/touch_point_calibrate_and_map_unit.sv
bench/tb.sv
